>>> src/scf_pkg.sv
// ----------------------------------------------------------------------------
// Scan curvature feature filter package
// Shared constants for the curvature filter and its channel interfaces.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int THRESH_W         = 50;
  localparam int SQ_IN_W          = THRESH_W / 2;
  localparam int DEF_HALF_WINDOW  = 5;
  localparam int DEF_COORD_BITS   = 20;

endpackage

>>> src/scf_point_if.sv
// ----------------------------------------------------------------------------
// Scan point channel
// Carries one scan point per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scf_point_if #(
  parameter int COORD_BITS = scf_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         scan_last;

  modport source (output valid, pos_x, pos_y, pos_z, scan_last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, scan_last, output ready);
endinterface

>>> src/scf_feat_if.sv
// ----------------------------------------------------------------------------
// Feature result channel
// Carries one feature or end-of-scan marker per request.
// ----------------------------------------------------------------------------
interface scf_feat_if #(
  parameter int COORD_BITS = scf_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] feat_x;
  logic signed [COORD_BITS-1:0] feat_y;
  logic signed [COORD_BITS-1:0] feat_z;
  logic                         point_valid;
  logic                         scan_end;

  modport source (output valid, feat_x, feat_y, feat_z, point_valid, scan_end,
                  input ready);
  modport sink   (input valid, feat_x, feat_y, feat_z, point_valid, scan_end,
                  output ready);
endinterface

>>> src/scf_cfg_if.sv
// ----------------------------------------------------------------------------
// Threshold configuration channel
// Carries the curvature threshold write data per request.
// ----------------------------------------------------------------------------
interface scf_cfg_if;
  import scf_pkg::*;

  logic                valid;
  logic                ready;
  logic [THRESH_W-1:0] curvature_threshold;

  modport source (output valid, curvature_threshold, input ready);
  modport sink   (input valid, curvature_threshold, output ready);
endinterface

>>> src/scan_curvature_feature_filter.sv
// ----------------------------------------------------------------------------
// Scan curvature feature filter
// Sliding-window curvature test over the points of a scan, emitting sharp
// points and one end-of-scan marker per scan.
// ----------------------------------------------------------------------------
// Accepts one point per clock cycle while the input is ready. The rate is set
// by the window update: the window shifts and the running x and y sums are
// adjusted by one add and, once the window is full, one subtract in the cycle
// the point is accepted. The curvature test then runs through three further
// register stages (difference, squares, threshold compare), the last of which
// is the output register; the input stays ready while any stage is empty or
// advancing, so a stalled result only holds the input once the pipeline has
// filled up behind it.
module scan_curvature_feature_filter #(
  parameter int HALF_WINDOW = scf_pkg::DEF_HALF_WINDOW,
  parameter int COORD_BITS  = scf_pkg::DEF_COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_point_if.sink  pt_in,
  scf_feat_if.source feat_out,
  scf_cfg_if.sink    cfg
);
  import scf_pkg::*;

  localparam int WIN_DEPTH = 2 * HALF_WINDOW + 1;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W     = COORD_BITS + $clog2(WIN_DEPTH);
  localparam int DIFF_W    = SUM_W + 1;

  // configuration
  logic [THRESH_W-1:0] thr_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg.valid) begin
      thr_q <= cfg.curvature_threshold;
    end
  end

  // handshake chain
  logic out_v_q, a_v_q, b_v_q, c_v_q;
  logic out_free, c_free, b_free, a_free, in_fire;

  assign out_free    = !out_v_q || feat_out.ready;
  assign c_free      = !c_v_q || out_free;
  assign b_free      = !b_v_q || c_free;
  assign a_free      = !a_v_q || b_free;
  assign pt_in.ready = a_free;
  assign in_fire     = pt_in.valid && a_free;

  // window and running sums
  logic signed [COORD_BITS-1:0] win_x_q [WIN_DEPTH];
  logic signed [COORD_BITS-1:0] win_y_q [WIN_DEPTH];
  logic signed [COORD_BITS-1:0] win_z_q [WIN_DEPTH];
  logic        [FILL_W-1:0]     fill_q, fill_d;
  logic signed [SUM_W-1:0]      sum_x_q, sum_y_q, sum_x_new, sum_y_new;
  logic                         win_full, judge_new;

  assign win_full  = fill_q == FILL_W'(WIN_DEPTH);
  assign judge_new = win_full || fill_q == FILL_W'(WIN_DEPTH - 1);

  always_comb begin
    sum_x_new = sum_x_q + SUM_W'(pt_in.pos_x);
    sum_y_new = sum_y_q + SUM_W'(pt_in.pos_y);
    fill_d    = fill_q;
    if (win_full) begin
      sum_x_new = sum_x_new - SUM_W'(win_x_q[0]);
      sum_y_new = sum_y_new - SUM_W'(win_y_q[0]);
    end else begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (in_fire) begin
      if (pt_in.scan_last) begin
        fill_q  <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else begin
        fill_q  <= fill_d;
        sum_x_q <= sum_x_new;
        sum_y_q <= sum_y_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if (win_full) begin
          if (i == WIN_DEPTH - 1) begin
            win_x_q[i] <= pt_in.pos_x;
            win_y_q[i] <= pt_in.pos_y;
            win_z_q[i] <= pt_in.pos_z;
          end else begin
            win_x_q[i] <= win_x_q[i+1];
            win_y_q[i] <= win_y_q[i+1];
            win_z_q[i] <= win_z_q[i+1];
          end
        end else if (fill_q == FILL_W'(i)) begin
          win_x_q[i] <= pt_in.pos_x;
          win_y_q[i] <= pt_in.pos_y;
          win_z_q[i] <= pt_in.pos_z;
        end
      end
    end
  end

  // stage A: sums and centre point after the update
  logic                         a_judge_q, a_last_q;
  logic signed [SUM_W-1:0]      a_sum_x_q, a_sum_y_q;
  logic signed [COORD_BITS-1:0] a_mx_q, a_my_q, a_mz_q;

  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_judge_q <= judge_new;
      a_last_q  <= pt_in.scan_last;
      a_sum_x_q <= sum_x_new;
      a_sum_y_q <= sum_y_new;
      if (win_full) begin
        a_mx_q <= win_x_q[HALF_WINDOW+1];
        a_my_q <= win_y_q[HALF_WINDOW+1];
        a_mz_q <= win_z_q[HALF_WINDOW+1];
      end else begin
        a_mx_q <= win_x_q[HALF_WINDOW];
        a_my_q <= win_y_q[HALF_WINDOW];
        a_mz_q <= win_z_q[HALF_WINDOW];
      end
    end
  end

  // stage B: differences and magnitudes
  logic signed [DIFF_W-1:0]     dx, dy;
  logic        [DIFF_W-1:0]     ax, ay;
  logic        [SQ_IN_W-1:0]    ax_sq_in, ay_sq_in;
  logic                         big;
  logic                         b_judge_q, b_last_q, b_big_q;
  logic        [SQ_IN_W-1:0]    b_ax_q, b_ay_q;
  logic signed [COORD_BITS-1:0] b_mx_q, b_my_q, b_mz_q;

  assign dx = DIFF_W'(a_sum_x_q) - DIFF_W'(a_mx_q) * DIFF_W'(WIN_DEPTH);
  assign dy = DIFF_W'(a_sum_y_q) - DIFF_W'(a_my_q) * DIFF_W'(WIN_DEPTH);
  assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  if (DIFF_W > SQ_IN_W) begin : g_big_wide
    assign big      = (|ax[DIFF_W-1:SQ_IN_W]) || (|ay[DIFF_W-1:SQ_IN_W]);
    assign ax_sq_in = ax[SQ_IN_W-1:0];
    assign ay_sq_in = ay[SQ_IN_W-1:0];
  end else begin : g_big_narrow
    assign big      = 1'b0;
    assign ax_sq_in = SQ_IN_W'(ax);
    assign ay_sq_in = SQ_IN_W'(ay);
  end

  always_ff @(posedge clk_i) begin
    if (b_free) begin
      b_judge_q <= a_judge_q;
      b_last_q  <= a_last_q;
      b_big_q   <= big;
      b_ax_q    <= ax_sq_in;
      b_ay_q    <= ay_sq_in;
      b_mx_q    <= a_mx_q;
      b_my_q    <= a_my_q;
      b_mz_q    <= a_mz_q;
    end
  end

  // stage C: squares
  logic                         c_judge_q, c_last_q, c_big_q;
  logic        [THRESH_W-1:0]   c_sqx_q, c_sqy_q;
  logic signed [COORD_BITS-1:0] c_mx_q, c_my_q, c_mz_q;

  always_ff @(posedge clk_i) begin
    if (c_free) begin
      c_judge_q <= b_judge_q;
      c_last_q  <= b_last_q;
      c_big_q   <= b_big_q;
      c_sqx_q   <= THRESH_W'(b_ax_q) * THRESH_W'(b_ax_q);
      c_sqy_q   <= THRESH_W'(b_ay_q) * THRESH_W'(b_ay_q);
      c_mx_q    <= b_mx_q;
      c_my_q    <= b_my_q;
      c_mz_q    <= b_mz_q;
    end
  end

  // output stage: threshold compare
  logic [THRESH_W:0]            curv;
  logic                         hit, emit;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic                         out_pv_q, out_end_q;

  assign curv = {1'b0, c_sqx_q} + {1'b0, c_sqy_q};
  assign hit  = c_judge_q && (c_big_q || curv > {1'b0, thr_q});
  assign emit = hit || c_last_q;

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_x_q   <= hit ? c_mx_q : '0;
      out_y_q   <= hit ? c_my_q : '0;
      out_z_q   <= hit ? c_mz_q : '0;
      out_pv_q  <= hit;
      out_end_q <= c_last_q;
    end
  end

  // advance valid bits, drop items with no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_q <= in_fire;
      end
      if (b_free) begin
        b_v_q <= a_v_q;
      end
      if (c_free) begin
        c_v_q <= b_v_q;
      end
      if (out_free) begin
        out_v_q <= c_v_q && emit;
      end
    end
  end

  assign feat_out.valid       = out_v_q;
  assign feat_out.feat_x      = out_x_q;
  assign feat_out.feat_y      = out_y_q;
  assign feat_out.feat_z      = out_z_q;
  assign feat_out.point_valid = out_pv_q;
  assign feat_out.scan_end    = out_end_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("window fill count beyond depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && pt_in.scan_last |=> fill_q == '0 && sum_x_q == '0 && sum_y_q == '0)
    else $error("window not cleared after last point");

  a_result_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_pv_q || out_end_q)
    else $error("result with neither feature nor scan end");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_pv_q |-> out_x_q == '0 && out_y_q == '0 && out_z_q == '0)
    else $error("non-feature result carries point data");

  a_last_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v_q && c_last_q && out_free |=> out_v_q && out_end_q)
    else $error("last point lost its end-of-scan result");

endmodule

>>> verif/tb_scan_curvature_feature_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan curvature feature filter testbench
// Streams scans of points through the filter under random input gaps and
// output stalls, predicts every feature and end-of-scan marker from its own
// window model or, for typed directed rows, from the table, and compares
// results in order, field by field. A short table of directed scans comes
// first, then random scans under several thresholds, each written when idle.
// ----------------------------------------------------------------------------
module tb_scan_curvature_feature_filter;
  import scf_pkg::*;

  localparam int CW     = DEF_COORD_BITS;
  localparam int HW     = DEF_HALF_WINDOW;
  localparam int WIN    = 2 * HW + 1;
  localparam int SETTLE = 10;
  localparam int LIMIT  = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_POINTS = 125;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   pv;
    logic   se;
  } feat_rec_t;

  typedef struct packed {
    point_t    pt;
    logic      last;
    logic      typed;
    logic      has;
    feat_rec_t res;
  } row_t;

  localparam coord_t MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t MINC = {1'b1, {(CW-1){1'b0}}};

  logic clk_i;
  logic rst_ni = 1'b0;

  scf_point_if #(.COORD_BITS(CW)) pt_if ();
  scf_feat_if  #(.COORD_BITS(CW)) feat_if ();
  scf_cfg_if                      cfg_if ();

  scan_curvature_feature_filter #(
    .HALF_WINDOW(HW),
    .COORD_BITS (CW)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pt_in   (pt_if),
    .feat_out(feat_if),
    .cfg     (cfg_if)
  );

  point_t              win_pts [WIN];
  int                  fill;
  longint              acc_x;
  longint              acc_y;
  logic [THRESH_W-1:0] thr;

  feat_rec_t pending_feats [$];
  row_t      directed_rows [$];

  logic      row_typed;
  logic      row_has;
  feat_rec_t row_res;

  bit  idle_on = 1'b1;
  bit  force_hold;
  int  errors;
  int  cycles;
  int  n_points;
  int  n_scans;
  int  n_cfg;
  int  n_results;
  int  n_feats;
  int  n_holds;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("[scan_curvature_feature_filter] ERROR");
      $finish;
    end
  end

  function automatic void clear_window();
    for (int i = 0; i < WIN; i++) win_pts[i] = '0;
    fill  = 0;
    acc_x = 0;
    acc_y = 0;
  endfunction

  function automatic void judge_point(input point_t p, input logic last,
                                      output logic hit, output feat_rec_t r);
    point_t             m;
    longint             dx;
    longint             dy;
    longint unsigned    ax;
    longint unsigned    ay;
    logic               sharp;
    if (fill >= WIN) begin
      acc_x -= longint'($signed(win_pts[0].x));
      acc_y -= longint'($signed(win_pts[0].y));
      for (int i = 0; i < WIN - 1; i++) win_pts[i] = win_pts[i+1];
      win_pts[WIN-1] = p;
    end else begin
      win_pts[fill] = p;
      fill++;
    end
    acc_x += longint'($signed(p.x));
    acc_y += longint'($signed(p.y));
    r = '0;
    if (fill == WIN) begin
      m  = win_pts[HW];
      dx = acc_x - longint'(WIN) * longint'($signed(m.x));
      dy = acc_y - longint'(WIN) * longint'($signed(m.y));
      ax = (dx < 0) ? longint'(-dx) : longint'(dx);
      ay = (dy < 0) ? longint'(-dy) : longint'(dy);
      if (ax >= (64'd1 << 25) || ay >= (64'd1 << 25)) begin
        sharp = 1'b1;
      end else begin
        sharp = (ax * ax + ay * ay) > longint'({14'd0, thr});
      end
      if (sharp) begin
        r.x  = m.x;
        r.y  = m.y;
        r.z  = m.z;
        r.pv = 1'b1;
      end
    end
    r.se = last;
    hit  = r.pv || last;
    if (last) clear_window();
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : watch
    point_t    p;
    logic      hit;
    feat_rec_t r;
    feat_rec_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) thr = cfg_if.curvature_threshold;
      if (pt_if.valid && pt_if.ready) begin
        p.x = pt_if.pos_x;
        p.y = pt_if.pos_y;
        p.z = pt_if.pos_z;
        judge_point(p, pt_if.scan_last, hit, r);
        if (row_typed) begin
          if (row_has) pending_feats.insert(pending_feats.size(), row_res);
        end else if (hit) begin
          pending_feats.insert(pending_feats.size(), r);
        end
      end
      if (feat_if.valid && feat_if.ready) begin
        n_results++;
        if (feat_if.point_valid) n_feats++;
        if (pending_feats.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = pending_feats.pop_front();
          if (feat_if.feat_x !== want.x)
            report_mismatch("feat_x", longint'($signed(feat_if.feat_x)),
                            longint'($signed(want.x)));
          if (feat_if.feat_y !== want.y)
            report_mismatch("feat_y", longint'($signed(feat_if.feat_y)),
                            longint'($signed(want.y)));
          if (feat_if.feat_z !== want.z)
            report_mismatch("feat_z", longint'($signed(feat_if.feat_z)),
                            longint'($signed(want.z)));
          if (feat_if.point_valid !== want.pv)
            report_mismatch("point_valid", feat_if.point_valid, want.pv);
          if (feat_if.scan_end !== want.se)
            report_mismatch("scan_end", feat_if.scan_end, want.se);
        end
      end
    end
  end

  initial begin : sink_side
    int n;
    feat_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        feat_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      feat_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_point(input point_t p, input logic last, input logic typed,
                            input logic has, input feat_rec_t res);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      pt_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    pt_if.valid     <= 1'b1;
    pt_if.pos_x     <= p.x;
    pt_if.pos_y     <= p.y;
    pt_if.pos_z     <= p.z;
    pt_if.scan_last <= last;
    row_typed       <= typed;
    row_has         <= has;
    row_res         <= res;
    do @(posedge clk_i); while (!pt_if.ready);
    n_points++;
    if (last) n_scans++;
  endtask

  task automatic add_row(input point_t p, input logic last, input logic typed,
                         input logic has, input feat_rec_t res);
    row_t row;
    row.pt    = p;
    row.last  = last;
    row.typed = typed;
    row.has   = has;
    row.res   = res;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic wait_drained();
    pt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_feats.size() != 0);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] v);
    cfg_if.valid               <= 1'b1;
    cfg_if.curvature_threshold <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic run_scan(input int len, input int mode);
    int          bx;
    int          by;
    int          stx;
    int          sty;
    int          amp;
    int          sx;
    int          sy;
    logic [31:0] bits;
    point_t      p;
    bx  = int'($urandom_range(0, 400000)) - 200000;
    by  = int'($urandom_range(0, 400000)) - 200000;
    stx = int'($urandom_range(0, 4000)) - 2000;
    sty = int'($urandom_range(0, 4000)) - 2000;
    amp = (mode == 1) ? 16 : 512;
    for (int i = 0; i < len; i++) begin
      if (i == len / 2 && (force_hold || $urandom_range(0, 15) == 0)) begin
        wait_drained();
        force_hold = 1'b0;
        n_holds++;
      end
      if (mode == 0) begin
        bits = $urandom;
        p.x  = bits[CW-1:0];
        bits = $urandom;
        p.y  = bits[CW-1:0];
      end else begin
        sx = 0;
        sy = 0;
        if ($urandom_range(0, 7) == 0) begin
          sx = int'($urandom_range(0, 20000)) - 10000;
          sy = int'($urandom_range(0, 20000)) - 10000;
        end
        p.x = coord_t'(bx + i * stx + int'($urandom_range(0, 2 * amp)) - amp + sx);
        p.y = coord_t'(by + i * sty + int'($urandom_range(0, 2 * amp)) - amp + sy);
      end
      bits = $urandom;
      p.z  = bits[CW-1:0];
      send_point(p, i == len - 1, 1'b0, 1'b0, '0);
    end
  endtask

  function automatic logic [THRESH_W-1:0] pick_threshold(input int ph);
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    case (ph)
      0: pick_threshold = rnd[THRESH_W-1:0];
      1: pick_threshold = '1;
      2: pick_threshold = '0;
      default: pick_threshold = rnd[THRESH_W-1:0] >> $urandom_range(10, THRESH_W - 1);
    endcase
  endfunction

  initial begin : stimulus
    point_t    p;
    feat_rec_t r;
    int        len;
    int        got;
    pt_if.valid                <= 1'b0;
    pt_if.pos_x                <= '0;
    pt_if.pos_y                <= '0;
    pt_if.pos_z                <= '0;
    pt_if.scan_last            <= 1'b0;
    cfg_if.valid               <= 1'b0;
    cfg_if.curvature_threshold <= '0;
    row_typed                  <= 1'b0;
    row_has                    <= 1'b0;
    row_res                    <= '0;
    clear_window();
    thr = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    p.x  = MAXC;
    p.y  = MINC;
    p.z  = '1;
    r    = '0;
    r.se = 1'b1;
    add_row(p, 1'b1, 1'b1, 1'b1, r);
    for (int k = 0; k < WIN; k++) begin
      if (k == HW) begin
        p.x = MINC;
        p.y = MAXC;
        p.z = MINC;
      end else begin
        p.x = MAXC;
        p.y = MINC;
        p.z = MAXC;
      end
      r.x  = MINC;
      r.y  = MAXC;
      r.z  = MINC;
      r.pv = 1'b1;
      r.se = 1'b1;
      if (k < WIN - 1) add_row(p, 1'b0, 1'b1, 1'b0, '0);
      else add_row(p, 1'b1, 1'b1, 1'b1, r);
    end
    for (int k = 0; k <= WIN; k++) begin
      p.x = coord_t'(k * 2000 - 11000 + ((k == HW) ? 300000 : 0));
      p.y = coord_t'(-k * 7 + ((k == HW + 1) ? -250000 : 0));
      p.z = coord_t'(k);
      add_row(p, k == WIN, 1'b0, 1'b0, '0);
    end
    foreach (directed_rows[i])
      send_point(directed_rows[i].pt, directed_rows[i].last, directed_rows[i].typed,
                 directed_rows[i].has, directed_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk_i);
      idle_on    = (ph != PHASES - 1);
      force_hold = (ph == 3);
      write_threshold(pick_threshold(ph));
      got = n_points;
      while (n_points - got < PHASE_POINTS) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WIN - 1)
                                          : $urandom_range(WIN, 40);
        run_scan(len, $urandom_range(0, 2));
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (pending_feats.size() != 0)
      report_mismatch("results still pending", pending_feats.size(), 0);
    $display("Sent %0d points in %0d scans under %0d threshold writes, %0d drain holds.",
             n_points, n_scans, n_cfg, n_holds);
    $display("Checked %0d results, %0d of them feature points, %0d mismatches.",
             n_results, n_feats, errors);
    if (errors == 0) begin
      $display("[scan_curvature_feature_filter] OK");
    end else begin
      $display("[scan_curvature_feature_filter] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/scf_pkg.sv
src/scf_point_if.sv
src/scf_feat_if.sv
src/scf_cfg_if.sv
src/scan_curvature_feature_filter.sv
verif/tb_scan_curvature_feature_filter.sv
